### rtl/rwf_pkg.sv
// ----------------------------------------------------------------------------
// rwf_pkg: shared types and constants
// Types, mode codes and sizes of the 3x3 RGB window filter.
// ----------------------------------------------------------------------------
package rwf_pkg;
   localparam int MaxWidth = 1024;
   localparam int AddrW    = 10;
   localparam int PixW     = 24;
   localparam int MaxHeight = 4096;

   typedef enum logic [1:0] {
      MODE_MEDIAN = 2'd0,
      MODE_GAUSS  = 2'd1,
      MODE_SOBELX = 2'd2,
      MODE_SOBELY = 2'd3
   } mode_type;

   localparam logic [1:0] CSR_MODE   = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   typedef logic [7:0] chan_win_type [9];

   // position data carried alongside the window through the pipe
   typedef struct packed {
      logic        emit;
      logic [11:0] row;
      logic [9:0]  col;
      logic        done;
   } tag_type;
endpackage

### rtl/rgb_3x3_window_filter_core.sv
// ----------------------------------------------------------------------------
// rgb_3x3_window_filter_core: 3x3 median / Gaussian / Sobel RGB filter
// Line buffers, window, three channel lanes and output merge.
// ----------------------------------------------------------------------------
// Pixels enter on req_ in raster order, one word per cycle. req_tuser marks
// the first pixel of a frame. For every interior pixel one word leaves on
// rsp_ with its row, column and filtered RGB; rsp_tlast flags the last
// interior pixel of the frame. Border pixels give no word.
// The pipe is: line-buffer read, window, lane stage 1, lane stage 2,
// output register: five register stages between req_ and rsp_.
// Throughput is one pixel per clock while rsp_ does not stall; the pipe is limited by the single
// read port of each line-buffer RAM, one read and one write per pixel.
// The whole pipe advances only when the output register is empty or being
// taken, so a stall on rsp_ holds everything and drops req_tready.
// Synchronous reset clears the counters, window, valid flags and registers
// (mode 0, width 640, height 480). Line buffers are not cleared; they are
// written before they are read in every regular frame.
// csr_ writes are taken any cycle and are meant only while the block is idle.
module rgb_3x3_window_filter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // in_red, in_green, in_blue
   input  logic        req_tuser,   // frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // out_row, out_col, out_red, out_green,
                                    // out_blue, zero fill
   output logic        rsp_tlast,   // frame_done
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   logic adv;
   logic rsp_valid_ff;
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   logic acc;
   assign acc = req_tvalid && adv;

   // configuration
   rwf_pkg::mode_type mode_ff;
   logic [10:0] width_ff;
   logic [12:0] height_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= rwf_pkg::MODE_MEDIAN;
         width_ff  <= 11'd640;
         height_ff <= 13'd480;
      end else if (csr_wr_en) begin
         case (csr_index)
            rwf_pkg::CSR_MODE:   mode_ff   <= rwf_pkg::mode_type'(csr_wdata[1:0]);
            rwf_pkg::CSR_WIDTH:  width_ff  <= csr_wdata[10:0];
            rwf_pkg::CSR_HEIGHT: height_ff <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   logic [10:0] w_eff;
   logic [12:0] h_eff;
   always_comb begin
      w_eff = (width_ff < 11'd3) ? 11'd3 :
              (width_ff > 11'(rwf_pkg::MaxWidth)) ? 11'(rwf_pkg::MaxWidth) : width_ff;
      h_eff = (height_ff < 13'd3) ? 13'd3 :
              (height_ff > 13'(rwf_pkg::MaxHeight)) ? 13'(rwf_pkg::MaxHeight) : height_ff;
   end

   // position counters
   logic [9:0]  col_ff, col_in, cur_col;
   logic [11:0] row_ff, row_in, cur_row;
   always_comb begin
      cur_col = req_tuser ? 10'd0 : col_ff;
      cur_row = req_tuser ? 12'd0 : row_ff;
      col_in = 10'(cur_col + 10'd1);
      row_in = cur_row;
      if ({1'b0, cur_col} >= 11'(w_eff - 11'd1)) begin
         col_in = 10'd0;
         if ({1'b0, cur_row} >= 13'(h_eff - 13'd1)) row_in = 12'd0;
         else row_in = 12'(cur_row + 12'd1);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= 10'd0;
         row_ff <= 12'd0;
      end else if (acc) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   rwf_pkg::tag_type tag0_in;
   always_comb begin
      tag0_in.emit = (cur_row >= 12'd2) && (cur_col >= 10'd2)
                     && ({1'b0, cur_row} < h_eff) && ({1'b0, cur_col} < w_eff);
      tag0_in.row  = 12'(cur_row - 12'd1);
      tag0_in.col  = 10'(cur_col - 10'd1);
      tag0_in.done = ({1'b0, cur_row} == 13'(h_eff - 13'd1))
                     && ({1'b0, cur_col} == 11'(w_eff - 11'd1));
   end

   // stage A: line buffer read, pixel held; read-modify-write at same column
   logic        va_ff;
   logic [23:0] px_a_ff;
   logic [9:0]  col_a_ff;
   rwf_pkg::tag_type tag_a_ff;
   logic [23:0] up_rd, mid_rd;
   logic        fwd_ff;
   logic [23:0] fwd_up_ff, fwd_mid_ff;
   logic [23:0] up_eff, mid_eff;

   // a frame start right after a column-0 pixel reads the column that stage A
   // is writing in the same cycle; take the values being written instead
   assign up_eff  = fwd_ff ? fwd_up_ff : up_rd;
   assign mid_eff = fwd_ff ? fwd_mid_ff : mid_rd;

   rwf_ram #(.Width(rwf_pkg::PixW), .Depth(rwf_pkg::MaxWidth)) u_upper (
      .clock(clock), .wr_en(va_ff && adv), .wr_addr(col_a_ff), .wr_data(mid_eff),
      .rd_en(adv), .rd_addr(cur_col), .rd_data(up_rd));
   rwf_ram #(.Width(rwf_pkg::PixW), .Depth(rwf_pkg::MaxWidth)) u_middle (
      .clock(clock), .wr_en(va_ff && adv), .wr_addr(col_a_ff), .wr_data(px_a_ff),
      .rd_en(adv), .rd_addr(cur_col), .rd_data(mid_rd));

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff  <= 1'b0;
         fwd_ff <= 1'b0;
      end else if (adv) begin
         va_ff  <= acc;
         fwd_ff <= va_ff && (col_a_ff == cur_col);
      end
      if (adv) begin
         px_a_ff    <= req_tdata;
         col_a_ff   <= cur_col;
         tag_a_ff   <= tag0_in;
         fwd_up_ff  <= mid_eff;
         fwd_mid_ff <= px_a_ff;
      end
   end

   // stage B: window shift
   logic [23:0] win_ff [9];
   logic        vb_ff;
   rwf_pkg::tag_type tag_b_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
         for (int i = 0; i < 9; i++) win_ff[i] <= '0;
      end else if (adv) begin
         vb_ff <= va_ff;
         if (va_ff) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[3*k]   <= win_ff[3*k+1];
               win_ff[3*k+1] <= win_ff[3*k+2];
            end
            win_ff[2] <= up_eff;
            win_ff[5] <= mid_eff;
            win_ff[8] <= px_a_ff;
         end
      end
      if (adv) tag_b_ff <= tag_a_ff;
   end

   // lanes (two stages) with tag alongside
   rwf_pkg::chan_win_type win_r, win_g, win_b;
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         win_r[i] = win_ff[i][7:0];
         win_g[i] = win_ff[i][15:8];
         win_b[i] = win_ff[i][23:16];
      end
   end
   logic [7:0] res_r, res_g, res_b;
   rwf_lane u_lane_r (.clock(clock), .adv(adv), .mode(mode_ff), .win(win_r), .result(res_r));
   rwf_lane u_lane_g (.clock(clock), .adv(adv), .mode(mode_ff), .win(win_g), .result(res_g));
   rwf_lane u_lane_b (.clock(clock), .adv(adv), .mode(mode_ff), .win(win_b), .result(res_b));

   logic vc_ff, vd_ff;
   rwf_pkg::tag_type tag_c_ff, tag_d_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (adv) begin
         vc_ff <= vb_ff && tag_b_ff.emit;
         vd_ff <= vc_ff;
      end
      if (adv) begin
         tag_c_ff <= tag_b_ff;
         tag_d_ff <= tag_c_ff;
      end
   end

   // merge into output register
   logic [47:0] rsp_data_ff;
   logic        rsp_last_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= vd_ff;
      if (adv) begin
         rsp_data_ff <= {2'd0, res_b, res_g, res_r, tag_d_ff.col, tag_d_ff.row};
         rsp_last_ff <= tag_d_ff.done;
      end
   end
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // assertions
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("result word changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_valid_ff || rsp_tready))
      else $error("input ready not tied to output space");
   a_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[11:0] != 12'd0 && rsp_data_ff[21:12] != 10'd0)
      else $error("border pixel emitted");
endmodule

### rtl/rwf_ram.sv
// ----------------------------------------------------------------------------
// rwf_ram: generic single-port-write, one-read RAM
// Registered read; read and write addresses may differ.
// ----------------------------------------------------------------------------
module rwf_ram #(
   parameter int Width = 24,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

### rtl/rwf_lane.sv
// ----------------------------------------------------------------------------
// rwf_lane: one color channel of the filter
// Two registered stages: partial sums/sort network, then final select.
// ----------------------------------------------------------------------------
module rwf_lane (
   input  logic                clock,
   input  logic                adv,
   input  rwf_pkg::mode_type   mode,
   input  rwf_pkg::chan_win_type win,
   output logic [7:0]          result
);
   // stage 1 registers
   logic [7:0] rowmed_ff [3], rowmed_in [3];
   logic [7:0] rowmin_ff [3], rowmin_in [3];
   logic [7:0] rowmax_ff [3], rowmax_in [3];
   logic [9:0] plus_ff, plus_in, minus_ff, minus_in;
   logic [7:0] gauss_ff, gauss_in;
   rwf_pkg::mode_type mode_ff;
   logic [7:0] result_ff, result_in;

   function automatic logic [7:0] mx(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? a : b;
   endfunction
   function automatic logic [7:0] mn(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? b : a;
   endfunction
   function automatic logic [7:0] md(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] c);
      return mx(mn(a, b), mn(mx(a, b), c));
   endfunction

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         rowmin_in[r] = mn(mn(win[3*r], win[3*r+1]), win[3*r+2]);
         rowmax_in[r] = mx(mx(win[3*r], win[3*r+1]), win[3*r+2]);
         rowmed_in[r] = md(win[3*r], win[3*r+1], win[3*r+2]);
      end
      gauss_in = 8'({4'd0, win[0][7:4]} + {4'd0, win[2][7:4]} + {4'd0, win[6][7:4]}
               + {4'd0, win[8][7:4]} + {3'd0, win[1][7:3]} + {3'd0, win[3][7:3]}
               + {3'd0, win[5][7:3]} + {3'd0, win[7][7:3]} + {2'd0, win[4][7:2]});
      if (mode == rwf_pkg::MODE_SOBELX) begin
         plus_in  = {2'd0, win[2]} + {1'b0, win[5], 1'b0} + {2'd0, win[8]};
         minus_in = {2'd0, win[0]} + {1'b0, win[3], 1'b0} + {2'd0, win[6]};
      end else begin
         plus_in  = {2'd0, win[6]} + {1'b0, win[7], 1'b0} + {2'd0, win[8]};
         minus_in = {2'd0, win[0]} + {1'b0, win[1], 1'b0} + {2'd0, win[2]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rowmin_ff <= rowmin_in;
         rowmax_ff <= rowmax_in;
         rowmed_ff <= rowmed_in;
         plus_ff   <= plus_in;
         minus_ff  <= minus_in;
         gauss_ff  <= gauss_in;
         mode_ff   <= mode;
      end
   end

   // median of nine = med(max of row mins, med of row meds, min of row maxes)
   logic [9:0] diff;
   always_comb begin
      diff = (plus_ff >= minus_ff) ? plus_ff - minus_ff : minus_ff - plus_ff;
      case (mode_ff)
         rwf_pkg::MODE_MEDIAN:
            result_in = md(mx(mx(rowmin_ff[0], rowmin_ff[1]), rowmin_ff[2]),
                           md(rowmed_ff[0], rowmed_ff[1], rowmed_ff[2]),
                           mn(mn(rowmax_ff[0], rowmax_ff[1]), rowmax_ff[2]));
         rwf_pkg::MODE_GAUSS: result_in = gauss_ff;
         default: result_in = (diff > 10'd255) ? 8'd255 : diff[7:0];
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) result_ff <= result_in;
   end
   assign result = result_ff;
endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: rgb_3x3_window_filter_core stream check
// Streams RGB frames of many sizes and all four filter modes into the core,
// predicts every interior word from a local model of the line buffers and
// the 3x3 window, and checks rsp_ words in order with random stalls.
// ----------------------------------------------------------------------------
module testbench;
   localparam int CycleLimit = 600000;
   localparam int SettleCycles = 12;

   typedef enum logic [1:0] {ITEM_PIX, ITEM_CSR, ITEM_DRAIN} item_kind_type;

   typedef struct {
      item_kind_type kind;
      logic [23:0]   px;
      bit            fs;
      logic [1:0]    idx;
      logic [12:0]   val;
   } stim_item_type;

   typedef struct {
      logic [11:0] row;
      logic [9:0]  col;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        done;
   } filt_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = rwf_pkg::CSR_MODE;
   logic [12:0] csr_wdata = '0;

   rgb_3x3_window_filter_core dut (.*);

   stim_item_type pending_items[$];
   filt_word_type expected_words[$];
   int            errors = 0;
   int            pix_count = 0;
   int            pix_taken = 0;
   int            cycles = 0;
   bit            req_fire = 0;
   bit            rsp_fire = 0;

   // local copy of the filter state
   logic [23:0] upper_mem [rwf_pkg::MaxWidth];
   logic [23:0] middle_mem [rwf_pkg::MaxWidth];
   logic [23:0] win [9];
   int          col_cnt;
   int          row_cnt;
   logic [1:0]  mode_r;
   logic [10:0] width_r;
   logic [12:0] height_r;

   initial clock = 0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("rgb_3x3_window_filter_core: mismatch");
         $finish;
      end
   end

   function automatic logic [7:0] filter_lane(input int sh);
      int v[9];
      int t, a, b, d;
      for (int i = 0; i < 9; i++) v[i] = win[i][sh +: 8];
      case (rwf_pkg::mode_type'(mode_r))
         rwf_pkg::MODE_MEDIAN: begin
            for (int i = 0; i < 8; i++)
               for (int j = 0; j < 8 - i; j++)
                  if (v[j] > v[j+1]) begin
                     t = v[j]; v[j] = v[j+1]; v[j+1] = t;
                  end
            return 8'(v[4]);
         end
         rwf_pkg::MODE_GAUSS:
            return 8'(v[0]/16 + v[2]/16 + v[6]/16 + v[8]/16
                 + v[1]/8 + v[3]/8 + v[5]/8 + v[7]/8 + v[4]/4);
         rwf_pkg::MODE_SOBELX: begin
            a = v[2] + 2*v[5] + v[8];
            b = v[0] + 2*v[3] + v[6];
         end
         default: begin
            a = v[6] + 2*v[7] + v[8];
            b = v[0] + 2*v[1] + v[2];
         end
      endcase
      d = (a >= b) ? a - b : b - a;
      return (d > 255) ? 8'd255 : d[7:0];
   endfunction

   function automatic bit filter_pixel(input logic [23:0] px, input bit fs,
                                       output filt_word_type r);
      int w, h, col, row;
      logic [23:0] up, mid;
      bit emit;
      w = width_r;
      h = height_r;
      if (w < 3) w = 3;
      if (w > rwf_pkg::MaxWidth) w = rwf_pkg::MaxWidth;
      if (h < 3) h = 3;
      if (h > rwf_pkg::MaxHeight) h = rwf_pkg::MaxHeight;
      if (fs) begin
         col_cnt = 0;
         row_cnt = 0;
      end
      col = col_cnt;
      row = row_cnt;
      if (col >= rwf_pkg::MaxWidth) col = rwf_pkg::MaxWidth - 1;
      up = upper_mem[col];
      mid = middle_mem[col];
      upper_mem[col] = mid;
      middle_mem[col] = px;
      for (int k = 0; k < 3; k++) begin
         win[3*k] = win[3*k+1];
         win[3*k+1] = win[3*k+2];
      end
      win[2] = up;
      win[5] = mid;
      win[8] = px;
      emit = row >= 2 && col >= 2 && row < h && col < w;
      if (emit) begin
         r.row = 12'(row - 1);
         r.col = 10'(col - 1);
         r.red = filter_lane(0);
         r.green = filter_lane(8);
         r.blue = filter_lane(16);
         r.done = (row == h - 1) && (col == w - 1);
      end
      if (col_cnt >= w - 1) begin
         col_cnt = 0;
         if (row_cnt >= h - 1) row_cnt = 0;
         else row_cnt = (row_cnt + 1) & 12'hFFF;
      end else begin
         col_cnt = (col_cnt + 1) & 10'h3FF;
      end
      return emit;
   endfunction

   // prediction on accepted words and in-order response check
   always @(posedge clock) begin
      filt_word_type e, got;
      req_fire <= req_tvalid && req_tready;
      rsp_fire <= rsp_tvalid && rsp_tready;
      if (reset) begin
         for (int i = 0; i < 9; i++) win[i] = '0;
         col_cnt = 0;
         row_cnt = 0;
         mode_r = rwf_pkg::MODE_MEDIAN;
         width_r = 11'd640;
         height_r = 13'd480;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == rwf_pkg::CSR_MODE) mode_r = csr_wdata[1:0];
            else if (csr_index == rwf_pkg::CSR_WIDTH) width_r = csr_wdata[10:0];
            else if (csr_index == rwf_pkg::CSR_HEIGHT) height_r = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            pix_taken++;
            if (filter_pixel(req_tdata, req_tuser, e)) expected_words.push_back(e);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.row = rsp_tdata[11:0];
            got.col = rsp_tdata[21:12];
            got.red = rsp_tdata[29:22];
            got.green = rsp_tdata[37:30];
            got.blue = rsp_tdata[45:38];
            got.done = rsp_tlast;
            if (expected_words.size() == 0) begin
               errors++;
               $display("%0t: unexpected word row %0d col %0d", $time, got.row, got.col);
            end else begin
               e = expected_words.pop_front();
               if (got != e) begin
                  errors++;
                  $display("%0t: expected row %0d col %0d rgb %h %h %h last %b",
                           $time, e.row, e.col, e.red, e.green, e.blue, e.done);
                  $display("%0t: actual   row %0d col %0d rgb %h %h %h last %b",
                           $time, got.row, got.col, got.red, got.green, got.blue,
                           got.done);
               end
            end
         end
      end
   end

   // sender
   int gap_left = 0;
   int quiet = 0;
   bit tx_idle = 1;
   always @(negedge clock) begin
      bit vld, wr;
      stim_item_type it;
      if (!reset) begin
         vld = req_tvalid;
         wr = 0;
         if (req_fire) vld = 0;
         if (!vld) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() != 0) begin
               it = pending_items[0];
               if (it.kind == ITEM_PIX) begin
                  void'(pending_items.pop_front());
                  vld = 1;
                  req_tdata <= it.px;
                  req_tuser <= it.fs;
                  gap_left = tx_idle ? $urandom_range(0, 5) : 0;
                  if ($urandom_range(0, 99) == 0) tx_idle = !tx_idle;
               end else begin
                  // block must be drained before a register write or a pause ends
                  if (expected_words.size() == 0) quiet++;
                  else quiet = 0;
                  if (quiet >= SettleCycles) begin
                     quiet = 0;
                     void'(pending_items.pop_front());
                     if (it.kind == ITEM_CSR) begin
                        wr = 1;
                        csr_index <= it.idx;
                        csr_wdata <= it.val;
                     end
                  end
               end
            end
         end
         req_tvalid <= vld;
         csr_wr_en <= wr;
      end
   end

   // receiver, with one long hold-off to back the pipe up
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 0;
   bit rx_idle = 1;
   always @(negedge clock) begin
      bit rdy;
      if (!reset) begin
         rdy = 1;
         if (rsp_fire) stall_left = rx_idle ? $urandom_range(0, 5) : 0;
         if (!hold_done && pix_taken >= 300) begin
            hold_done = 1;
            hold_left = 200;
         end
         if (hold_left > 0) begin
            hold_left--;
            rdy = 0;
         end else if (stall_left > 0) begin
            stall_left--;
            rdy = 0;
         end
         if ($urandom_range(0, 199) == 0) rx_idle = !rx_idle;
         rsp_tready <= rdy;
      end
   end

   task automatic push_pixel(input logic [23:0] px, input bit fs);
      stim_item_type it;
      it.kind = ITEM_PIX;
      it.px = px;
      it.fs = fs;
      it.idx = rwf_pkg::CSR_MODE;
      it.val = '0;
      pending_items.push_back(it);
      pix_count++;
   endtask

   task automatic push_ctl(input item_kind_type kind, input logic [1:0] idx,
                           input logic [12:0] val);
      stim_item_type it;
      it.kind = kind;
      it.px = '0;
      it.fs = 0;
      it.idx = idx;
      it.val = val;
      pending_items.push_back(it);
   endtask

   function automatic logic [23:0] rand_pixel(input int style);
      logic [23:0] p;
      for (int c = 0; c < 3; c++)
         case (style)
            0: p[8*c +: 8] = 8'($urandom_range(0, 255));
            1: p[8*c +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: p[8*c +: 8] = 8'(8'd120 + $urandom_range(0, 15));
         endcase
      return p;
   endfunction

   // rows full rows of w pixels plus extra pixels of a partial row
   task automatic push_frame(input int w, input int rows, input int extra,
                             input bit fs);
      int style;
      style = $urandom_range(0, 2);
      for (int i = 0; i < rows * w + extra; i++)
         push_pixel(rand_pixel(style), fs && i == 0);
   endtask

   initial begin
      int w, h, eff_w, eff_h, nfr, rows, extra;
      bit partial, fs, drain_sent;
      logic [23:0] p;
      reset = 1;
      drain_sent = 0;

      // directed: one 3x3 frame per mode with extreme values
      push_ctl(ITEM_CSR, rwf_pkg::CSR_WIDTH, 13'd3);
      push_ctl(ITEM_CSR, rwf_pkg::CSR_HEIGHT, 13'd3);
      for (int m = 0; m < 4; m++) begin
         push_ctl(ITEM_CSR, rwf_pkg::CSR_MODE, m[12:0]);
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++) begin
               case (m)
                  0: p = ((r + c) % 2) ? 24'hFFFFFF : 24'h000000;
                  1: p = 24'hFFFFFF;
                  2: p = (c == 2) ? 24'hFFFFFF : 24'h00FF00;
                  default: p = (r == 0) ? 24'hFF00FF : 24'h00FF00;
               endcase
               push_pixel(p, r == 0 && c == 0);
            end
      end

      // one wide frame, three rows
      push_ctl(ITEM_CSR, rwf_pkg::CSR_WIDTH, 13'd250);
      push_frame(250, 3, 0, 1);

      while (pix_count < 1200) begin
         case ($urandom_range(0, 9))
            0: w = $urandom_range(0, 2);
            1: w = $urandom_range(20, 40);
            default: w = $urandom_range(3, 12);
         endcase
         case ($urandom_range(0, 9))
            0: h = $urandom_range(0, 2);
            1: h = $urandom_range(0, 1) ? 8191 : 4096;
            default: h = $urandom_range(3, 6);
         endcase
         eff_w = (w < 3) ? 3 : w;
         eff_h = (h < 3) ? 3 : (h > rwf_pkg::MaxHeight ? rwf_pkg::MaxHeight : h);
         push_ctl(ITEM_CSR, rwf_pkg::CSR_MODE, 13'($urandom_range(0, 3)));
         push_ctl(ITEM_CSR, rwf_pkg::CSR_WIDTH, w[12:0]);
         push_ctl(ITEM_CSR, rwf_pkg::CSR_HEIGHT, h[12:0]);
         nfr = $urandom_range(1, 3);
         partial = 1;
         for (int f = 0; f < nfr; f++) begin
            fs = partial || $urandom_range(0, 3) != 0;
            partial = eff_h > 8 || $urandom_range(0, 9) == 0;
            if (partial) begin
               rows = $urandom_range(0, (eff_h > 8) ? 5 : eff_h - 1);
               extra = $urandom_range(0, eff_w - 1);
            end else begin
               rows = eff_h;
               extra = 0;
            end
            push_frame(eff_w, rows, extra, fs);
            if (!drain_sent && pix_count > 700) begin
               push_ctl(ITEM_DRAIN, rwf_pkg::CSR_MODE, '0);
               drain_sent = 1;
            end
         end
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      while (pending_items.size() != 0 || req_tvalid || expected_words.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) $display("rgb_3x3_window_filter_core: match");
      else $display("rgb_3x3_window_filter_core: mismatch");
      $finish;
   end
endmodule
